/* design/cps_pkg.sv */
// cps_pkg: word types, fixed-point widths and the t-select code for the
// capsule coverage pixel shader. No dependencies.
package cps_pkg;

  // field widths of the words
  localparam int COORD_W          = 16;
  localparam int RAD_W            = 8;
  localparam int GRAY_W           = 8;
  localparam int PIXEL_COORD_BITS = 11;

  // internal fixed-point widths
  localparam int REL_W   = 18;  // pixel centre minus start, 1/16 px, signed
  localparam int AB_W    = 17;  // end minus start, signed
  localparam int SQ_W    = 33;  // one squared component of the segment
  localparam int LEN_W   = 34;  // squared segment length
  localparam int DP_W    = 35;  // one product of the dot product, signed
  localparam int DOT_W   = 36;  // dot product, signed
  localparam int T_FRAC  = 16;  // fraction bits of t
  localparam int T_W     = 17;  // t in 0..65536
  localparam int PROJ_W  = 35;  // segment component times t, signed
  localparam int RD_W    = 9;   // radius difference, signed
  localparam int RPROD_W = 27;  // radius difference times t, signed
  localparam int DX_W    = 37;  // distance component in 2^-20 px, signed
  localparam int AX_W    = 23;  // |distance component| in 1/256 px
  localparam int AXSQ_W  = 46;
  localparam int RAD2_W  = 48;  // squared distance, padded to even width
  localparam int ROOT_W  = RAD2_W / 2;
  localparam int R_W     = 13;  // radius in 1/256 px
  localparam int COV_W   = 26;  // coverage, signed

  typedef enum logic [1:0] {
    TM_ZERO,
    TM_ONE,
    TM_DIV
  } t_mode_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]          start_x;
    logic signed [COORD_W-1:0]          start_y;
    logic        [RAD_W-1:0]            start_radius;
    logic signed [COORD_W-1:0]          end_x;
    logic signed [COORD_W-1:0]          end_y;
    logic        [RAD_W-1:0]            end_radius;
    logic        [PIXEL_COORD_BITS-1:0] pixel_col;
    logic        [PIXEL_COORD_BITS-1:0] pixel_row;
    logic        [GRAY_W-1:0]           current_gray;
  } in_word_t;

  typedef struct packed {
    logic [GRAY_W-1:0] ink_gray;
    logic              write_pixel;
  } out_word_t;

  // data that rides alongside the divider
  typedef struct packed {
    logic signed [REL_W-1:0] rel_x;
    logic signed [REL_W-1:0] rel_y;
    logic signed [AB_W-1:0]  ab_x;
    logic signed [AB_W-1:0]  ab_y;
    logic        [RAD_W-1:0] r0;
    logic        [RAD_W-1:0] r1;
    logic        [GRAY_W-1:0] gray;
    t_mode_t                 mode;
  } div_side_t;

  // data that rides alongside the square root
  typedef struct packed {
    logic [R_W-1:0]    radius;
    logic [GRAY_W-1:0] gray;
  } sqrt_side_t;

endpackage

/* design/cps_div.sv */
// cps_div: pipelined restoring divider, one quotient bit per stage.
// Depends on cps_pkg.
module cps_div import cps_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [LEN_W-1:0]   in_num,
  input  logic [LEN_W-1:0]   in_den,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  output logic [T_FRAC-1:0]  out_quot,
  output logic [SIDE_W-1:0]  out_side
);

  logic              valid_r [T_FRAC];
  logic [LEN_W-1:0]  rem_r   [T_FRAC];
  logic [LEN_W-1:0]  den_r   [T_FRAC];
  logic [T_FRAC-1:0] quot_r  [T_FRAC];
  logic [SIDE_W-1:0] side_r  [T_FRAC];

  for (genvar i = 0; i < T_FRAC; i++) begin : g_step
    logic              v_in;
    logic [LEN_W-1:0]  rem_in;
    logic [LEN_W-1:0]  den_in;
    logic [T_FRAC-1:0] quot_in;
    logic [SIDE_W-1:0] side_in;
    logic [LEN_W:0]    shifted;
    logic [LEN_W:0]    diff;
    logic [LEN_W-1:0]  rem_nxt;
    logic [T_FRAC-1:0] quot_nxt;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quot_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = valid_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
      assign quot_in = quot_r[i-1];
      assign side_in = side_r[i-1];
    end

    // shift in a zero, subtract the divisor when it fits
    always_comb begin
      shifted = {rem_in, 1'b0};
      diff    = shifted - {1'b0, den_in};
      if (shifted >= {1'b0, den_in}) begin
        rem_nxt  = diff[LEN_W-1:0];
        quot_nxt = {quot_in[T_FRAC-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted[LEN_W-1:0];
        quot_nxt = {quot_in[T_FRAC-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (adv) begin
        valid_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]  <= rem_nxt;
        den_r[i]  <= den_in;
        quot_r[i] <= quot_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = valid_r[T_FRAC-1];
  assign out_quot  = quot_r[T_FRAC-1];
  assign out_side  = side_r[T_FRAC-1];

endmodule

/* design/cps_sqrt.sv */
// cps_sqrt: pipelined integer square root, one root bit per stage (floor).
// Depends on cps_pkg.
module cps_sqrt import cps_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [RAD2_W-1:0]  in_rad,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  output logic [ROOT_W-1:0]  out_root,
  output logic [SIDE_W-1:0]  out_side
);

  localparam int REM_W = ROOT_W + 2;

  logic              valid_r [ROOT_W];
  logic [REM_W-1:0]  rem_r   [ROOT_W];
  logic [ROOT_W-1:0] root_r  [ROOT_W];
  logic [RAD2_W-1:0] rad_r   [ROOT_W];
  logic [SIDE_W-1:0] side_r  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic              v_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD2_W-1:0] rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W+1:0]  cat;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = valid_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign side_in = side_r[i-1];
    end

    // bring down two radicand bits, try root*4+1
    always_comb begin
      cat   = {rem_in, rad_in[RAD2_W-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      diff  = cat - trial;
      if (cat >= trial) begin
        rem_nxt  = diff[REM_W-1:0];
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = cat[REM_W-1:0];
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (adv) begin
        valid_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        rad_r[i]  <= {rad_in[RAD2_W-3:0], 2'b00};
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = valid_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

/* design/capsule_coverage_pixel_shader.sv */
// capsule_coverage_pixel_shader: per-pixel coverage and ink gray of an
// antialiased variable-radius capsule. Depends on cps_pkg, cps_div, cps_sqrt.
//
//   channel | ports                          | word
//   --------+--------------------------------+----------------------------
//   input   | in_valid, in_stall, in_word    | in_word_t: segment, pixel
//   result  | out_valid, out_stall, out_word | out_word_t: ink, write flag
//
// One word enters per cycle while in_stall is low, and every word gives exactly
// one result word. The pipe has three front stages, 16 divider stages (one
// quotient bit of t each), four stages for projection and squares, 24
// square-root stages (one root bit each) and the coverage/output register.
// rst_n (synchronous) clears the valid bits only; data registers are free.
// The whole pipe holds while the output register is full and stalled;
// in_stall follows that hold, so nothing is dropped or repeated.
module capsule_coverage_pixel_shader import cps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic adv;

  // advance whenever the output register can take a word
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 1: offsets from the start point ----------------
  logic [PIXEL_COORD_BITS+3:0] px, py;
  logic signed [REL_W-1:0]     rel_x_nxt, rel_y_nxt;
  logic signed [AB_W-1:0]      ab_x_nxt, ab_y_nxt;

  logic                    s1_valid_r;
  logic signed [REL_W-1:0] s1_rel_x_r, s1_rel_y_r;
  logic signed [AB_W-1:0]  s1_ab_x_r, s1_ab_y_r;
  logic [RAD_W-1:0]        s1_r0_r, s1_r1_r;
  logic [GRAY_W-1:0]       s1_gray_r;

  always_comb begin
    // pixel centre in 1/16 px: col*16 + 8
    px = {in_word.pixel_col, 4'b1000};
    py = {in_word.pixel_row, 4'b1000};
    rel_x_nxt = $signed({{(REL_W-PIXEL_COORD_BITS-4){1'b0}}, px})
              - $signed({{(REL_W-COORD_W){in_word.start_x[COORD_W-1]}}, in_word.start_x});
    rel_y_nxt = $signed({{(REL_W-PIXEL_COORD_BITS-4){1'b0}}, py})
              - $signed({{(REL_W-COORD_W){in_word.start_y[COORD_W-1]}}, in_word.start_y});
    ab_x_nxt  = $signed({in_word.end_x[COORD_W-1], in_word.end_x})
              - $signed({in_word.start_x[COORD_W-1], in_word.start_x});
    ab_y_nxt  = $signed({in_word.end_y[COORD_W-1], in_word.end_y})
              - $signed({in_word.start_y[COORD_W-1], in_word.start_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rel_x_r <= rel_x_nxt;
      s1_rel_y_r <= rel_y_nxt;
      s1_ab_x_r  <= ab_x_nxt;
      s1_ab_y_r  <= ab_y_nxt;
      s1_r0_r    <= in_word.start_radius;
      s1_r1_r    <= in_word.end_radius;
      s1_gray_r  <= in_word.current_gray;
    end
  end

  // ---------------- stage 2: squares and dot-product terms ----------------
  logic signed [2*AB_W-1:0] sq_x_full, sq_y_full;
  logic signed [DP_W-1:0]   dp_x_nxt, dp_y_nxt;

  logic                    s2_valid_r;
  logic [SQ_W-1:0]         s2_sq_x_r, s2_sq_y_r;
  logic signed [DP_W-1:0]  s2_dp_x_r, s2_dp_y_r;
  logic signed [REL_W-1:0] s2_rel_x_r, s2_rel_y_r;
  logic signed [AB_W-1:0]  s2_ab_x_r, s2_ab_y_r;
  logic [RAD_W-1:0]        s2_r0_r, s2_r1_r;
  logic [GRAY_W-1:0]       s2_gray_r;

  always_comb begin
    sq_x_full = (2*AB_W)'(s1_ab_x_r) * (2*AB_W)'(s1_ab_x_r);
    sq_y_full = (2*AB_W)'(s1_ab_y_r) * (2*AB_W)'(s1_ab_y_r);
    dp_x_nxt  = DP_W'(s1_rel_x_r) * DP_W'(s1_ab_x_r);
    dp_y_nxt  = DP_W'(s1_rel_y_r) * DP_W'(s1_ab_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sq_x_r  <= sq_x_full[SQ_W-1:0];
      s2_sq_y_r  <= sq_y_full[SQ_W-1:0];
      s2_dp_x_r  <= dp_x_nxt;
      s2_dp_y_r  <= dp_y_nxt;
      s2_rel_x_r <= s1_rel_x_r;
      s2_rel_y_r <= s1_rel_y_r;
      s2_ab_x_r  <= s1_ab_x_r;
      s2_ab_y_r  <= s1_ab_y_r;
      s2_r0_r    <= s1_r0_r;
      s2_r1_r    <= s1_r1_r;
      s2_gray_r  <= s1_gray_r;
    end
  end

  // ---------------- stage 3: length, dot, pick how t is found ----------------
  logic [LEN_W-1:0]        len_nxt;
  logic signed [DOT_W-1:0] dot_nxt;
  t_mode_t                 mode_nxt;

  logic             s3_valid_r;
  logic [LEN_W-1:0] s3_len_r;
  logic [LEN_W-1:0] s3_num_r;
  div_side_t        s3_side_r;

  always_comb begin
    len_nxt = {1'b0, s2_sq_x_r} + {1'b0, s2_sq_y_r};
    dot_nxt = $signed({s2_dp_x_r[DP_W-1], s2_dp_x_r})
            + $signed({s2_dp_y_r[DP_W-1], s2_dp_y_r});
    // zero-length segment or pixel behind the start: t = 0
    if (len_nxt == '0 || dot_nxt[DOT_W-1] || dot_nxt == '0) begin
      mode_nxt = TM_ZERO;
    end else if (dot_nxt >= $signed({{(DOT_W-LEN_W){1'b0}}, len_nxt})) begin
      mode_nxt = TM_ONE;
    end else begin
      mode_nxt = TM_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_len_r        <= len_nxt;
      s3_num_r        <= dot_nxt[LEN_W-1:0];
      s3_side_r.rel_x <= s2_rel_x_r;
      s3_side_r.rel_y <= s2_rel_y_r;
      s3_side_r.ab_x  <= s2_ab_x_r;
      s3_side_r.ab_y  <= s2_ab_y_r;
      s3_side_r.r0    <= s2_r0_r;
      s3_side_r.r1    <= s2_r1_r;
      s3_side_r.gray  <= s2_gray_r;
      s3_side_r.mode  <= mode_nxt;
    end
  end

  // ---------------- divider: t = floor(dot * 2^16 / len) ----------------
  logic              div_valid;
  logic [T_FRAC-1:0] div_quot;
  logic [$bits(div_side_t)-1:0] div_side_bits;
  div_side_t         div_side;

  cps_div #(
    .SIDE_W ($bits(div_side_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s3_valid_r),
    .in_num    (s3_num_r),
    .in_den    (s3_len_r),
    .in_side   (s3_side_r),
    .out_valid (div_valid),
    .out_quot  (div_quot),
    .out_side  (div_side_bits)
  );

  assign div_side = div_side_t'(div_side_bits);

  // ---------------- stage 4: scale segment and radius by t ----------------
  logic [T_W-1:0]            t_nxt;
  logic signed [T_W:0]       t_s;
  logic signed [RD_W-1:0]    rdiff;
  logic signed [PROJ_W-1:0]  proj_x_nxt, proj_y_nxt;
  logic signed [RPROD_W-1:0] rprod_nxt;

  logic                      s4_valid_r;
  logic signed [PROJ_W-1:0]  s4_proj_x_r, s4_proj_y_r;
  logic signed [RPROD_W-1:0] s4_rprod_r;
  logic signed [REL_W-1:0]   s4_rel_x_r, s4_rel_y_r;
  logic [RAD_W-1:0]          s4_r0_r;
  logic [GRAY_W-1:0]         s4_gray_r;

  always_comb begin
    case (div_side.mode)
      TM_ZERO: t_nxt = '0;
      TM_ONE:  t_nxt = {1'b1, {T_FRAC{1'b0}}};
      TM_DIV:  t_nxt = {1'b0, div_quot};
      default: t_nxt = '0;
    endcase
    t_s        = $signed({1'b0, t_nxt});
    rdiff      = $signed({1'b0, div_side.r1}) - $signed({1'b0, div_side.r0});
    proj_x_nxt = PROJ_W'(div_side.ab_x) * PROJ_W'(t_s);
    proj_y_nxt = PROJ_W'(div_side.ab_y) * PROJ_W'(t_s);
    rprod_nxt  = RPROD_W'(rdiff) * RPROD_W'(t_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_proj_x_r <= proj_x_nxt;
      s4_proj_y_r <= proj_y_nxt;
      s4_rprod_r  <= rprod_nxt;
      s4_rel_x_r  <= div_side.rel_x;
      s4_rel_y_r  <= div_side.rel_y;
      s4_r0_r     <= div_side.r0;
      s4_gray_r   <= div_side.gray;
    end
  end

  // ---------------- stage 5: distance components and radius ----------------
  logic signed [DX_W-1:0]    dx, dy;
  logic [DX_W-1:0]           abs_x, abs_y, rnd_x, rnd_y;
  logic signed [RPROD_W-1:0] rq, rq_rnd;

  logic              s5_valid_r;
  logic [AX_W-1:0]   s5_ax_r, s5_ay_r;
  logic [R_W-1:0]    s5_radius_r;
  logic [GRAY_W-1:0] s5_gray_r;

  always_comb begin
    dx = $signed({{(DX_W-REL_W-T_FRAC){s4_rel_x_r[REL_W-1]}}, s4_rel_x_r, {T_FRAC{1'b0}}})
       - $signed({{(DX_W-PROJ_W){s4_proj_x_r[PROJ_W-1]}}, s4_proj_x_r});
    dy = $signed({{(DX_W-REL_W-T_FRAC){s4_rel_y_r[REL_W-1]}}, s4_rel_y_r, {T_FRAC{1'b0}}})
       - $signed({{(DX_W-PROJ_W){s4_proj_y_r[PROJ_W-1]}}, s4_proj_y_r});
    abs_x = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
    abs_y = dy[DX_W-1] ? DX_W'(-dy) : DX_W'(dy);
    // round half up from 2^-20 px to 1/256 px
    rnd_x  = abs_x + DX_W'(2048);
    rnd_y  = abs_y + DX_W'(2048);
    rq     = $signed({{(RPROD_W-RAD_W-T_FRAC){1'b0}}, s4_r0_r, {T_FRAC{1'b0}}}) + s4_rprod_r;
    rq_rnd = rq + RPROD_W'(2048);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ax_r     <= rnd_x[12 +: AX_W];
      s5_ay_r     <= rnd_y[12 +: AX_W];
      s5_radius_r <= rq_rnd[12 +: R_W];
      s5_gray_r   <= s4_gray_r;
    end
  end

  // ---------------- stage 6: squares of the components ----------------
  logic              s6_valid_r;
  logic [AXSQ_W-1:0] s6_sq_x_r, s6_sq_y_r;
  sqrt_side_t        s6_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (adv) begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_sq_x_r        <= AXSQ_W'(s5_ax_r) * AXSQ_W'(s5_ax_r);
      s6_sq_y_r        <= AXSQ_W'(s5_ay_r) * AXSQ_W'(s5_ay_r);
      s6_side_r.radius <= s5_radius_r;
      s6_side_r.gray   <= s5_gray_r;
    end
  end

  // ---------------- stage 7: squared distance ----------------
  logic              s7_valid_r;
  logic [RAD2_W-1:0] s7_rad_r;
  sqrt_side_t        s7_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else if (adv) begin
      s7_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_rad_r  <= {{(RAD2_W-AXSQ_W){1'b0}}, s6_sq_x_r}
                 + {{(RAD2_W-AXSQ_W){1'b0}}, s6_sq_y_r};
      s7_side_r <= s6_side_r;
    end
  end

  // ---------------- square root: d in 1/256 px ----------------
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [$bits(sqrt_side_t)-1:0] sq_side_bits;
  sqrt_side_t        sq_side;

  cps_sqrt #(
    .SIDE_W ($bits(sqrt_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s7_valid_r),
    .in_rad    (s7_rad_r),
    .in_side   (s7_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side_bits)
  );

  assign sq_side = sqrt_side_t'(sq_side_bits);

  // ---------------- coverage, ink and output register ----------------
  logic signed [COV_W-1:0] cov;
  logic [8:0]              cov_clamp;
  logic [7:0]              inv_cov;
  logic [15:0]             ink_sum;
  out_word_t               word_nxt;

  logic      out_valid_r;
  out_word_t out_word_r;

  always_comb begin
    // coverage = r + half pixel - d, all in 1/256 px
    cov = $signed({{(COV_W-R_W){1'b0}}, sq_side.radius}) + COV_W'(128)
        - $signed({{(COV_W-ROOT_W){1'b0}}, sq_root});
    cov_clamp = (cov > COV_W'(256)) ? 9'd256 : cov[8:0];
    inv_cov   = 8'(9'd256 - cov_clamp);
    ink_sum   = {8'd0, inv_cov} * 16'd255 + 16'd128;
    // no coverage: paint nothing, report white
    if (!cov[COV_W-1] && cov != '0) begin
      word_nxt.ink_gray    = ink_sum[15:8];
      word_nxt.write_pixel = (ink_sum[15:8] < sq_side.gray);
    end else begin
      word_nxt.ink_gray    = 8'd255;
      word_nxt.write_pixel = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking testbench for capsule_coverage_pixel_shader.
// Depends on cps_pkg and the shader RTL; a built-in coverage predictor checks
// every result word in order.
module tb_top import cps_pkg::*; ();

  localparam int LATENCY     = 48;
  localparam int RANDOM_WORDS = 1850;
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  capsule_coverage_pixel_shader dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // expected ink words, oldest first
  out_word_t ink_queue[$];
  int        errors;
  int        cycles;
  bit        long_hold;

  // Floor square root, one result bit per step.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Round |v| from 2^-20 px to 1/256 px, half up.
  function automatic longint unsigned to_sub256(longint v);
    longint unsigned a;
    a = (v < 0) ? longint'(-v) : v;
    return (a + 2048) >> 12;
  endfunction

  // Shade one pixel: project, interpolate radius, compute coverage and ink.
  function automatic out_word_t shade_pixel(in_word_t w);
    out_word_t       res;
    longint          sx, sy, ex, ey, r0, r1, px, py;
    longint          abx, aby, len_sq, dot, t, dx, dy, rq, r, cov;
    longint unsigned ax, ay, d, ink;
    sx = longint'(w.start_x);
    sy = longint'(w.start_y);
    ex = longint'(w.end_x);
    ey = longint'(w.end_y);
    r0 = longint'(w.start_radius);
    r1 = longint'(w.end_radius);
    px = longint'(w.pixel_col) * 16 + 8;
    py = longint'(w.pixel_row) * 16 + 8;
    abx = ex - sx;
    aby = ey - sy;
    len_sq = abx * abx + aby * aby;
    t = 0;
    if (len_sq != 0) begin
      dot = (px - sx) * abx + (py - sy) * aby;
      if (dot <= 0) t = 0;
      else if (dot >= len_sq) t = 65536;
      else t = (dot * 65536) / len_sq;
    end
    dx = px * 65536 - (sx * 65536 + abx * t);
    dy = py * 65536 - (sy * 65536 + aby * t);
    rq = r0 * 65536 + (r1 - r0) * t;
    ax = to_sub256(dx);
    ay = to_sub256(dy);
    d = root_floor(ax * ax + ay * ay);
    r = (rq + 2048) >>> 12;
    cov = r + 128 - longint'(d);
    res.ink_gray = 8'hFF;
    res.write_pixel = 1'b0;
    if (cov > 0) begin
      if (cov > 256) cov = 256;
      ink = ((256 - cov) * 255 + 128) >> 8;
      res.ink_gray = ink[7:0];
      res.write_pixel = (ink < w.current_gray);
    end
    return res;
  endfunction

  // Directed rows; has_exp marks rows whose ink word is read off directly.
  typedef struct {
    in_word_t  w;
    bit        has_exp;
    out_word_t exp;
  } row_t;
  row_t rows[$];

  function automatic in_word_t mk(int sx, int sy, int r0, int ex, int ey, int r1,
                                  int col, int row, int gray);
    in_word_t w;
    w.start_x = COORD_W'(sx); w.start_y = COORD_W'(sy); w.start_radius = RAD_W'(r0);
    w.end_x = COORD_W'(ex); w.end_y = COORD_W'(ey); w.end_radius = RAD_W'(r1);
    w.pixel_col = PIXEL_COORD_BITS'(col); w.pixel_row = PIXEL_COORD_BITS'(row);
    w.current_gray = GRAY_W'(gray);
    return w;
  endfunction

  task automatic add_row(in_word_t w, bit has_exp, int ink, bit wr);
    row_t rw;
    rw.w = w;
    rw.has_exp = has_exp;
    rw.exp.ink_gray = GRAY_W'(ink);
    rw.exp.write_pixel = wr;
    rows.push_back(rw);
  endtask

  // Random capsule near its pixel, so coverage is often partial.
  function automatic in_word_t near_word();
    in_word_t w;
    int       cx, cy;
    w.pixel_col = PIXEL_COORD_BITS'($urandom_range(0, 2047));
    w.pixel_row = PIXEL_COORD_BITS'($urandom_range(0, 2047));
    cx = int'(w.pixel_col) * 16 + 8;
    cy = int'(w.pixel_row) * 16 + 8;
    w.start_x = COORD_W'(cx + int'($urandom_range(0, 160)) - 80);
    w.start_y = COORD_W'(cy + int'($urandom_range(0, 160)) - 80);
    w.end_x = ($urandom_range(0, 3) == 0) ? w.start_x
            : COORD_W'(cx + int'($urandom_range(0, 400)) - 200);
    w.end_y = ($urandom_range(0, 3) == 0) ? w.start_y
            : COORD_W'(cy + int'($urandom_range(0, 400)) - 200);
    w.start_radius = RAD_W'($urandom_range(0, 255));
    w.end_radius = RAD_W'($urandom_range(0, 255));
    w.current_gray = GRAY_W'($urandom_range(0, 255));
    return w;
  endfunction

  // Drop valid only across an idle gap; back-to-back words keep it high.
  task automatic send_word(in_word_t w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 4) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    // hold the word until the block takes it
    do @(posedge clk); while (in_stall);
  endtask

  // Accepted input words feed the predictor here, on the same edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) ink_queue.push_back(shade_pixel(in_word));
  end

  // Check results against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (ink_queue.size() == 0) begin
        $display("%0t: unexpected result ink=%0d wr=%0b", $time,
                 out_word.ink_gray, out_word.write_pixel);
        errors++;
      end else begin
        want = ink_queue.pop_front();
        if (want.ink_gray !== out_word.ink_gray) begin
          $display("%0t: ink_gray expected %0d actual %0d", $time,
                   want.ink_gray, out_word.ink_gray);
          errors++;
        end
        if (want.write_pixel !== out_word.write_pixel) begin
          $display("%0t: write_pixel expected %0b actual %0b", $time,
                   want.write_pixel, out_word.write_pixel);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall before each result, with quiet stretches and
  // one long hold-off so the pipe fills and backs up into the input.
  initial begin
    int wait_n;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Cycle limit as a watchdog.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    in_word_t w;
    errors = 0;
    long_hold = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // far pixel: no coverage, white ink
    add_row(mk(0, 0, 0, 0, 0, 0, 2047, 2047, 255), 1, 255, 0);
    // pixel centre on a fat disc: full coverage, black ink, write
    add_row(mk(8, 8, 255, 8, 8, 255, 0, 0, 255), 1, 0, 1);
    // full coverage but already black: no write
    add_row(mk(8, 8, 255, 8, 8, 0, 0, 0, 0), 1, 0, 0);
    // extreme coordinates on both ends
    add_row(mk(-32768, -32768, 255, 32767, 32767, 255, 2047, 2047, 255), 0, 0, 0);
    add_row(mk(32767, -32768, 0, -32768, 32767, 255, 0, 2047, 128), 0, 0, 0);
    add_row(mk(-32768, 32767, 255, -32768, 32767, 0, 1024, 1024, 200), 0, 0, 0);
    // zero-length segment near pixel: disc of start radius
    add_row(mk(24, 24, 10, 24, 24, 200, 1, 1, 255), 0, 0, 0);
    add_row(mk(30, 8, 20, 30, 8, 20, 1, 0, 77), 0, 0, 0);
    // projection before start, past end, and inside
    add_row(mk(100, 100, 40, 300, 100, 200, 4, 6, 255), 0, 0, 0);
    add_row(mk(100, 100, 40, 300, 100, 200, 20, 6, 255), 0, 0, 0);
    add_row(mk(100, 100, 40, 300, 100, 200, 12, 6, 255), 0, 0, 0);
    add_row(mk(100, 100, 40, 300, 300, 0, 12, 12, 255), 0, 0, 0);
    // partial coverage edges, ink equal to gray
    add_row(mk(8, 8, 8, 8, 8, 8, 0, 1, 255), 0, 0, 0);
    add_row(mk(8, 8, 8, 8, 8, 8, 0, 1, 0), 0, 0, 0);
    add_row(mk(-100, 500, 255, 2000, -300, 1, 50, 10, 170), 0, 0, 0);
    add_row(mk(16'h5555, 16'h2AAA, 8'h55, 16'hAAAA, 16'hD555, 8'hAA,
               11'h555, 11'h2AA, 8'h55), 0, 0, 0);

    // directed part: typed-in rows checked directly, others by predictor
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        w = rows[i].w;
        if (shade_pixel(w) !== rows[i].exp) begin
          $display("%0t: row %0d expected %0d/%0b actual %0d/%0b", $time, i,
                   rows[i].exp.ink_gray, rows[i].exp.write_pixel,
                   shade_pixel(w).ink_gray, shade_pixel(w).write_pixel);
          errors++;
        end
      end
      send_word(rows[i].w);
    end

    // random part: mostly capsules near their pixel, some raw noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 600) long_hold = 1'b1;
      if ($urandom_range(0, 4) == 0) w = in_word_t'({$urandom, $urandom, $urandom, $urandom});
      else w = near_word();
      send_word(w);
    end
    in_valid <= 1'b0;

    // drain the expected words, then linger before the verdict
    @(posedge clk);
    while (ink_queue.size() != 0) @(posedge clk);
    repeat (LATENCY * 2) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
design/cps_pkg.sv
design/cps_div.sv
design/cps_sqrt.sv
design/capsule_coverage_pixel_shader.sv
verif/tb_top.sv
